// ----- src/ttf_pkg.sv -----
// Shared types and constants for the triangle tangent frame block.
// No dependencies; imported by every module of the block but ttf_mul.
package ttf_pkg;

  // Vertex store geometry (depth must be a power of two: slots wrap on the low bits)
  localparam int VERTEX_DEPTH = 1024;
  localparam int ADDR_W       = $clog2(VERTEX_DEPTH);

  // Command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TRI  = 1'b1;

  // Fixed-point unit length in Q1.14
  localparam int UNIT_Q14 = 16384;

  // Datapath widths
  localparam int VEC_W = 35;  // raw binormal, tangent and normal components
  localparam int MAG_W = 30;  // magnitudes after range shift
  localparam int SUM_W = 62;  // sum of squared magnitudes
  localparam int LEN_W = 31;  // integer square root of the sum
  localparam int NUM_W = 45;  // divide numerator
  localparam int QUO_W = 15;  // divide quotient
  localparam int REM_W = 35;  // partial remainder of root and divide

  // Root/divide unit request
  typedef enum logic {
    RD_SQRT,
    RD_DIV
  } rd_op_e;

  typedef struct packed {
    logic   start;
    rd_op_e op;
  } rd_req_t;

endpackage

// ----- src/ttf_vstore.sv -----
// Vertex store: positions (3 x Q7.8) and texture coordinates (2 x Q3.12).
// One write port, one read port with registered data. Depends on ttf_pkg.
module ttf_vstore (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [ttf_pkg::ADDR_W-1:0] wr_addr_i,
  input  logic [47:0]               wr_pos_i,
  input  logic [31:0]               wr_tex_i,
  input  logic [ttf_pkg::ADDR_W-1:0] rd_addr_i,
  output logic [47:0]               rd_pos_o,
  output logic [31:0]               rd_tex_o
);
  import ttf_pkg::*;

  logic [47:0] pos_mem [VERTEX_DEPTH];
  logic [31:0] tex_mem [VERTEX_DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      pos_mem[wr_addr_i] <= wr_pos_i;
      tex_mem[wr_addr_i] <= wr_tex_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rd_pos_o <= pos_mem[rd_addr_i];
    rd_tex_o <= tex_mem[rd_addr_i];
  end

endmodule

// ----- src/ttf_mul.sv -----
// Shared signed 32x32 multiplier with a registered product.
// Depends on nothing but the clock.
module ttf_mul (
  input  logic               clk_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic signed [63:0] p_o
);

  always_ff @(posedge clk_i) begin
    p_o <= a_i * b_i;
  end

endmodule

// ----- src/ttf_rootdiv.sv -----
// Iterative integer square root (two radicand bits per cycle) and
// restoring divide (one quotient bit per cycle) on one shared subtractor.
// Depends on ttf_pkg.
module ttf_rootdiv (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ttf_pkg::rd_req_t            req_i,
  input  logic [ttf_pkg::SUM_W-1:0]   radicand_i,
  input  logic [ttf_pkg::NUM_W-1:0]   num_i,
  input  logic [ttf_pkg::LEN_W-1:0]   den_i,
  output logic                        done_o,
  output logic [ttf_pkg::LEN_W-1:0]   root_o,
  output logic [ttf_pkg::QUO_W-1:0]   quot_o
);
  import ttf_pkg::*;

  logic             run_q;
  rd_op_e           op_q;
  logic [4:0]       cnt_q;
  logic [REM_W-1:0] rem_q;
  logic [SUM_W-1:0] src_q;
  logic [LEN_W-1:0] res_q;

  logic [REM_W-1:0] r2, cmp, rem_d;
  logic             ge;

  // One step: shift in source bits, compare against trial value or divisor
  always_comb begin
    if (op_q == RD_SQRT) begin
      r2  = {rem_q[REM_W-3:0], src_q[SUM_W-1:SUM_W-2]};
      cmp = {2'b00, res_q, 2'b01};
    end else begin
      r2  = {rem_q[REM_W-2:0], src_q[SUM_W-1]};
      cmp = {{(REM_W-LEN_W){1'b0}}, den_i};
    end
    ge    = (r2 >= cmp);
    rem_d = ge ? (r2 - cmp) : r2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (req_i.start) begin
        run_q <= 1'b1;
        op_q  <= req_i.op;
        res_q <= '0;
        if (req_i.op == RD_SQRT) begin
          rem_q <= '0;
          src_q <= radicand_i;
          cnt_q <= 5'(LEN_W - 1);
        end else begin
          // top quotient bits are known zero: start with the high numerator part
          rem_q <= REM_W'(num_i[NUM_W-1:QUO_W]);
          src_q <= {num_i[QUO_W-1:0], {(SUM_W-QUO_W){1'b0}}};
          cnt_q <= 5'(QUO_W - 1);
        end
      end else if (run_q) begin
        rem_q <= rem_d;
        res_q <= {res_q[LEN_W-2:0], ge};
        src_q <= (op_q == RD_SQRT) ? (src_q << 2) : (src_q << 1);
        if (cnt_q == 5'd0) begin
          run_q  <= 1'b0;
          done_o <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 5'd1;
        end
      end
    end
  end

  assign root_o = res_q;
  assign quot_o = res_q[QUO_W-1:0];

endmodule

// ----- src/triangle_tangent_frame.sv -----
// Triangle tangent frame generator: top level with the corner sequencer.
// Uses ttf_pkg, ttf_vstore, ttf_mul and ttf_rootdiv.
//
// Usage:
//  - Commands are taken when start is high and busy is low. cmd_i = load
//    writes one vertex (position Q7.8, texcoord Q3.12) into the store in
//    that cycle; busy does not rise and no result follows.
//  - cmd_i = triangle names three store entries. busy stays high until the
//    third result has been shown. Each corner gives one result: unit tangent
//    and binormal in Q1.14, the corner field as vertex_id_o, a degenerate
//    flag, and last_corner_o on the third.
//  - Each result is held for one cycle with result_valid_o high; the
//    receiver cannot stall and must take it then.
//  - A corner's work is set by the bit-serial root/divide unit (one square
//    root and three divides per vector, three vectors per corner) and the
//    single shared multiplier (36 products per corner); a vector of zero
//    length skips its root and divides, so such a corner finishes sooner.
//  - Reset clears the sequencer and the result strobe; the vertex store is
//    not cleared and must be loaded before a triangle names an entry.
module triangle_tangent_frame (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               cmd_i,
  input  logic [9:0]         vertex_slot_i,
  input  logic signed [15:0] pos_x_i,
  input  logic signed [15:0] pos_y_i,
  input  logic signed [15:0] pos_z_i,
  input  logic signed [15:0] tex_u_i,
  input  logic signed [15:0] tex_v_i,
  input  logic [9:0]         corner_a_i,
  input  logic [9:0]         corner_b_i,
  input  logic [9:0]         corner_c_i,
  output logic               result_valid_o,
  output logic [9:0]         vertex_id_o,
  output logic signed [15:0] tangent_x_o,
  output logic signed [15:0] tangent_y_o,
  output logic signed [15:0] tangent_z_o,
  output logic signed [15:0] binormal_x_o,
  output logic signed [15:0] binormal_y_o,
  output logic signed [15:0] binormal_z_o,
  output logic               degenerate_o,
  output logic               last_corner_o
);
  import ttf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_CAP, S_EDGE, S_FM, S_FA, S_NABS, S_SQM, S_SQA,
    S_NCHK, S_SQRT, S_DIVS, S_DIVW, S_DM, S_DA, S_FIN
  } state_e;

  // vector slots: normal, binormal, tangent
  localparam logic [1:0] V_NRM = 2'd0;
  localparam logic [1:0] V_BIN = 2'd1;
  localparam logic [1:0] V_TAN = 2'd2;

  state_e state_q;
  logic       emit_q;
  logic [9:0] idx_q [3];
  logic [1:0] corner_q, fidx_q, vsel_q, comp_q, dstep_q;
  logic       term_q;

  logic signed [15:0] pos_q [3][3];
  logic signed [15:0] tex_q [3][2];
  logic signed [16:0] e1_q [3];
  logic signed [16:0] e2_q [3];
  logic signed [16:0] du1_q, du2_q, dv1_q, dv2_q;
  logic signed [VEC_W-1:0] vec_q [3][3];
  logic signed [VEC_W-1:0] facc_q;
  logic [MAG_W-1:0] sm_q [3];
  logic [SUM_W-1:0] sum_q;
  logic [LEN_W-1:0] len_q;
  logic signed [15:0] unit_q [3][3];
  logic zflag_q;
  logic signed [30:0] cross_q;
  logic signed [47:0] dacc_q;
  rd_req_t rd_req_q;

  logic               valid_q, degen_q, last_q;
  logic [9:0]         vid_q;
  logic signed [15:0] tan_o_q [3];
  logic signed [15:0] bin_o_q [3];

  // rotate a 0..2 index by one
  function automatic logic [1:0] nxt3(input logic [1:0] c);
    return (c == 2'd2) ? 2'd0 : c + 2'd1;
  endfunction

  // ---------------- store ----------------
  logic [ADDR_W-1:0] rd_addr;
  logic [47:0]       rd_pos;
  logic [31:0]       rd_tex;
  logic [1:0]        fsel;

  always_comb begin
    case (fidx_q)
      2'd0:    fsel = corner_q;
      2'd1:    fsel = nxt3(corner_q);
      default: fsel = nxt3(nxt3(corner_q));
    endcase
    rd_addr = ADDR_W'(idx_q[fsel]);
  end

  ttf_vstore u_vstore (
    .clk_i     (clk_i),
    .we_i      (start && !busy && (cmd_i == CMD_LOAD)),
    .wr_addr_i (ADDR_W'(vertex_slot_i)),
    .wr_pos_i  ({pos_x_i, pos_y_i, pos_z_i}),
    .wr_tex_i  ({tex_u_i, tex_v_i}),
    .rd_addr_i (rd_addr),
    .rd_pos_o  (rd_pos),
    .rd_tex_o  (rd_tex)
  );

  // ---------------- multiplier operand select ----------------
  logic [1:0] c1, c2;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;

  assign c1 = nxt3(comp_q);
  assign c2 = nxt3(c1);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_FM: begin
        case (vsel_q)
          V_NRM: begin
            mul_a = term_q ? 32'(e1_q[c2]) : 32'(e1_q[c1]);
            mul_b = term_q ? 32'(e2_q[c1]) : 32'(e2_q[c2]);
          end
          V_BIN: begin
            mul_a = term_q ? 32'(e2_q[comp_q]) : 32'(e1_q[comp_q]);
            mul_b = term_q ? 32'(du1_q) : 32'(du2_q);
          end
          default: begin
            mul_a = term_q ? 32'(e2_q[comp_q]) : 32'(e1_q[comp_q]);
            mul_b = term_q ? 32'(dv1_q) : 32'(dv2_q);
          end
        endcase
      end
      S_SQM: begin
        mul_a = {2'b00, sm_q[comp_q]};
        mul_b = {2'b00, sm_q[comp_q]};
      end
      S_DM: begin
        case (dstep_q)
          2'd0: begin
            mul_a = 32'(unit_q[V_TAN][c1]);
            mul_b = 32'(unit_q[V_BIN][c2]);
          end
          2'd1: begin
            mul_a = 32'(unit_q[V_TAN][c2]);
            mul_b = 32'(unit_q[V_BIN][c1]);
          end
          default: begin
            mul_a = 32'(cross_q);
            mul_b = 32'(unit_q[V_NRM][comp_q]);
          end
        endcase
      end
      default: ;
    endcase
  end

  ttf_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // ---------------- magnitude and range shift ----------------
  logic [VEC_W-1:0] mag [3];
  logic [VEC_W-1:0] mag_or;
  logic [2:0]       sh;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = vec_q[vsel_q][i][VEC_W-1] ? VEC_W'(-vec_q[vsel_q][i])
                                         : VEC_W'(vec_q[vsel_q][i]);
    end
    mag_or = mag[0] | mag[1] | mag[2];
    if (mag_or[34])      sh = 3'd5;
    else if (mag_or[33]) sh = 3'd4;
    else if (mag_or[32]) sh = 3'd3;
    else if (mag_or[31]) sh = 3'd2;
    else if (mag_or[30]) sh = 3'd1;
    else                 sh = 3'd0;
  end

  // ---------------- root / divide ----------------
  logic             rd_done;
  logic [LEN_W-1:0] root;
  logic [QUO_W-1:0] quot, qclamp;
  logic [NUM_W-1:0] div_num;

  assign div_num = {1'b0, sm_q[comp_q], 14'b0} + NUM_W'(len_q >> 1);
  assign qclamp  = (quot > QUO_W'(UNIT_Q14)) ? QUO_W'(UNIT_Q14) : quot;

  ttf_rootdiv u_rootdiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (rd_req_q),
    .radicand_i (sum_q),
    .num_i      (div_num),
    .den_i      (len_q),
    .done_o     (rd_done),
    .root_o     (root),
    .quot_o     (quot)
  );

  // ---------------- sequencer ----------------
  assign busy = (state_q != S_IDLE) || emit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      emit_q   <= 1'b0;
      valid_q  <= 1'b0;
      rd_req_q <= '{start: 1'b0, op: RD_SQRT};
      corner_q <= '0;
      fidx_q   <= '0;
      vsel_q   <= '0;
      comp_q   <= '0;
      dstep_q  <= '0;
      term_q   <= 1'b0;
    end else begin
      valid_q        <= 1'b0;
      rd_req_q.start <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (emit_q) begin
            // result cycle: move to next corner or finish
            emit_q <= 1'b0;
            if (corner_q != 2'd2) begin
              corner_q <= corner_q + 2'd1;
              fidx_q   <= '0;
              state_q  <= S_RD;
            end
          end else if (start && (cmd_i == CMD_TRI)) begin
            idx_q[0] <= corner_a_i;
            idx_q[1] <= corner_b_i;
            idx_q[2] <= corner_c_i;
            corner_q <= '0;
            fidx_q   <= '0;
            state_q  <= S_RD;
          end
        end
        S_RD: state_q <= S_CAP;
        S_CAP: begin
          pos_q[fidx_q][0] <= rd_pos[47:32];
          pos_q[fidx_q][1] <= rd_pos[31:16];
          pos_q[fidx_q][2] <= rd_pos[15:0];
          tex_q[fidx_q][0] <= rd_tex[31:16];
          tex_q[fidx_q][1] <= rd_tex[15:0];
          if (fidx_q == 2'd2) begin
            state_q <= S_EDGE;
          end else begin
            fidx_q  <= fidx_q + 2'd1;
            state_q <= S_RD;
          end
        end
        S_EDGE: begin
          for (int i = 0; i < 3; i++) begin
            e1_q[i] <= {pos_q[1][i][15], pos_q[1][i]} - {pos_q[0][i][15], pos_q[0][i]};
            e2_q[i] <= {pos_q[2][i][15], pos_q[2][i]} - {pos_q[0][i][15], pos_q[0][i]};
          end
          du1_q   <= {tex_q[0][0][15], tex_q[0][0]} - {tex_q[1][0][15], tex_q[1][0]};
          du2_q   <= {tex_q[2][0][15], tex_q[2][0]} - {tex_q[0][0][15], tex_q[0][0]};
          dv1_q   <= {tex_q[0][1][15], tex_q[0][1]} - {tex_q[1][1][15], tex_q[1][1]};
          dv2_q   <= {tex_q[2][1][15], tex_q[2][1]} - {tex_q[0][1][15], tex_q[0][1]};
          vsel_q  <= V_NRM;
          comp_q  <= '0;
          term_q  <= 1'b0;
          zflag_q <= 1'b0;
          state_q <= S_FM;
        end
        // form normal, binormal, tangent: two products per component
        S_FM: state_q <= S_FA;
        S_FA: begin
          state_q <= S_FM;
          if (!term_q) begin
            facc_q <= prod[VEC_W-1:0];
            term_q <= 1'b1;
          end else begin
            vec_q[vsel_q][comp_q] <= facc_q - prod[VEC_W-1:0];
            term_q <= 1'b0;
            if (comp_q == 2'd2) begin
              comp_q <= '0;
              if (vsel_q == V_TAN) begin
                vsel_q  <= V_NRM;
                state_q <= S_NABS;
              end else begin
                vsel_q <= vsel_q + 2'd1;
              end
            end else begin
              comp_q <= comp_q + 2'd1;
            end
          end
        end
        // normalize the selected vector
        S_NABS: begin
          for (int i = 0; i < 3; i++) sm_q[i] <= MAG_W'(mag[i] >> sh);
          sum_q   <= '0;
          comp_q  <= '0;
          state_q <= S_SQM;
        end
        S_SQM: state_q <= S_SQA;
        S_SQA: begin
          sum_q <= sum_q + prod[SUM_W-1:0];
          if (comp_q == 2'd2) begin
            comp_q  <= '0;
            state_q <= S_NCHK;
          end else begin
            comp_q  <= comp_q + 2'd1;
            state_q <= S_SQM;
          end
        end
        S_NCHK: begin
          if (sum_q == '0) begin
            for (int i = 0; i < 3; i++) unit_q[vsel_q][i] <= '0;
            zflag_q <= 1'b1;
            if (vsel_q == V_TAN) begin
              dacc_q  <= '0;
              dstep_q <= '0;
              state_q <= S_DM;
            end else begin
              vsel_q  <= vsel_q + 2'd1;
              state_q <= S_NABS;
            end
          end else begin
            rd_req_q <= '{start: 1'b1, op: RD_SQRT};
            state_q  <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (rd_done) begin
            len_q   <= root;
            comp_q  <= '0;
            state_q <= S_DIVS;
          end
        end
        S_DIVS: begin
          rd_req_q <= '{start: 1'b1, op: RD_DIV};
          state_q  <= S_DIVW;
        end
        S_DIVW: begin
          if (rd_done) begin
            unit_q[vsel_q][comp_q] <= vec_q[vsel_q][comp_q][VEC_W-1]
                                      ? -{1'b0, qclamp} : {1'b0, qclamp};
            if (comp_q == 2'd2) begin
              comp_q <= '0;
              if (vsel_q == V_TAN) begin
                dacc_q  <= '0;
                dstep_q <= '0;
                state_q <= S_DM;
              end else begin
                vsel_q  <= vsel_q + 2'd1;
                state_q <= S_NABS;
              end
            end else begin
              comp_q  <= comp_q + 2'd1;
              state_q <= S_DIVS;
            end
          end
        end
        // sign of (tangent x binormal) . normal
        S_DM: state_q <= S_DA;
        S_DA: begin
          state_q <= S_DM;
          case (dstep_q)
            2'd0: begin
              cross_q <= prod[30:0];
              dstep_q <= 2'd1;
            end
            2'd1: begin
              cross_q <= cross_q - prod[30:0];
              dstep_q <= 2'd2;
            end
            default: begin
              dacc_q  <= dacc_q + prod[47:0];
              dstep_q <= 2'd0;
              if (comp_q == 2'd2) begin
                comp_q  <= '0;
                state_q <= S_FIN;
              end else begin
                comp_q <= comp_q + 2'd1;
              end
            end
          endcase
        end
        S_FIN: begin
          for (int i = 0; i < 3; i++) begin
            tan_o_q[i] <= dacc_q[47] ? -unit_q[V_TAN][i] : unit_q[V_TAN][i];
            bin_o_q[i] <= dacc_q[47] ? -unit_q[V_BIN][i] : unit_q[V_BIN][i];
          end
          vid_q   <= idx_q[corner_q];
          degen_q <= zflag_q;
          last_q  <= (corner_q == 2'd2);
          valid_q <= 1'b1;
          emit_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // ---------------- result ports ----------------
  assign result_valid_o = valid_q;
  assign vertex_id_o    = vid_q;
  assign tangent_x_o    = tan_o_q[0];
  assign tangent_y_o    = tan_o_q[1];
  assign tangent_z_o    = tan_o_q[2];
  assign binormal_x_o   = bin_o_q[0];
  assign binormal_y_o   = bin_o_q[1];
  assign binormal_z_o   = bin_o_q[2];
  assign degenerate_o   = degen_q;
  assign last_corner_o  = last_q;

`ifndef SYNTH
  a_strobe_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy)
    else $error("result strobe outside a triangle transfer");

  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_corner_o |=> !busy)
    else $error("busy held after last corner");

  a_tri_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (cmd_i == CMD_TRI) |=> busy)
    else $error("triangle command did not raise busy");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (tangent_x_o <= 16'sd16384) && (tangent_x_o >= -16'sd16384)
                    && (binormal_x_o <= 16'sd16384) && (binormal_x_o >= -16'sd16384))
    else $error("unit component out of Q1.14 range");
`endif

endmodule

// ----- dv/triangle_tangent_frame_test.sv -----
// Self-checking testbench for triangle_tangent_frame: loads vertices, sends triangles,
// predicts every corner frame in the testbench and compares each result strobe.
// Depends on ttf_pkg and the triangle_tangent_frame RTL.
`timescale 1ns / 1ps

module triangle_tangent_frame_test;
  import ttf_pkg::*;

  typedef struct {
    logic        cmd;
    logic [9:0]  slot;
    logic [15:0] px, py, pz, u, v;
    logic [9:0]  ca, cb, cc;
  } cmd_item_t;

  typedef struct {
    logic [9:0]  vid;
    logic [15:0] tan [3];
    logic [15:0] bin [3];
    logic        degen;
    logic        last;
  } frame_t;

  typedef longint vec3_t [3];

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic cmd_i = CMD_LOAD;
  logic [9:0] vertex_slot_i = '0;
  logic signed [15:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0, tex_u_i = '0, tex_v_i = '0;
  logic [9:0] corner_a_i = '0, corner_b_i = '0, corner_c_i = '0;
  logic result_valid_o;
  logic [9:0] vertex_id_o;
  logic signed [15:0] tangent_x_o, tangent_y_o, tangent_z_o;
  logic signed [15:0] binormal_x_o, binormal_y_o, binormal_z_o;
  logic degenerate_o, last_corner_o;

  cmd_item_t pending_cmds [$];
  frame_t    expected_frames [$];
  int        mismatch_count = 0;

  // testbench copy of the vertex store
  longint pos_mem [VERTEX_DEPTH][3];
  longint tex_mem [VERTEX_DEPTH][2];

  always #2 clk_i = ~clk_i;

  triangle_tangent_frame i_dut (
    .clk_i, .rst_ni, .start, .busy, .cmd_i, .vertex_slot_i,
    .pos_x_i, .pos_y_i, .pos_z_i, .tex_u_i, .tex_v_i,
    .corner_a_i, .corner_b_i, .corner_c_i,
    .result_valid_o, .vertex_id_o,
    .tangent_x_o, .tangent_y_o, .tangent_z_o,
    .binormal_x_o, .binormal_y_o, .binormal_z_o,
    .degenerate_o, .last_corner_o
  );

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Q1.14 unit vector; returns 1 on zero length
  function automatic bit to_unit(input vec3_t c, output vec3_t o);
    longint unsigned mag [3];
    longint unsigned peak, sum, len, q;
    int sh;
    peak = 0;
    sum = 0;
    sh = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = c[i] < 0 ? -c[i] : c[i];
      if (mag[i] > peak) peak = mag[i];
    end
    while ((peak >> sh) >= (64'd1 << 30)) sh++;
    for (int i = 0; i < 3; i++) begin
      mag[i] >>= sh;
      sum += mag[i] * mag[i];
    end
    if (sum == 0) begin
      for (int i = 0; i < 3; i++) o[i] = 0;
      return 1'b1;
    end
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = (mag[i] * UNIT_Q14 + len / 2) / len;
      if (q > UNIT_Q14) q = UNIT_Q14;
      o[i] = c[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 1'b0;
  endfunction

  function automatic frame_t corner_frame(input int p, input int q, input int r,
                                          input logic [9:0] vid, input logic last);
    vec3_t e1, e2, bv, tv, nv, nrm, tn, bn;
    longint du1, du2, dv1, dv2, d;
    bit z;
    frame_t f;
    for (int i = 0; i < 3; i++) begin
      e1[i] = pos_mem[q][i] - pos_mem[p][i];
      e2[i] = pos_mem[r][i] - pos_mem[p][i];
    end
    du1 = tex_mem[p][0] - tex_mem[q][0];
    du2 = tex_mem[r][0] - tex_mem[p][0];
    dv1 = tex_mem[p][1] - tex_mem[q][1];
    dv2 = tex_mem[r][1] - tex_mem[p][1];
    for (int i = 0; i < 3; i++) begin
      bv[i] = e1[i] * du2 - e2[i] * du1;
      tv[i] = e1[i] * dv2 - e2[i] * dv1;
    end
    nv[0] = e1[1] * e2[2] - e1[2] * e2[1];
    nv[1] = e1[2] * e2[0] - e1[0] * e2[2];
    nv[2] = e1[0] * e2[1] - e1[1] * e2[0];
    z = to_unit(nv, nrm);
    z = to_unit(bv, bn) | z;
    z = to_unit(tv, tn) | z;
    d = (tn[1] * bn[2] - tn[2] * bn[1]) * nrm[0]
      + (tn[2] * bn[0] - tn[0] * bn[2]) * nrm[1]
      + (tn[0] * bn[1] - tn[1] * bn[0]) * nrm[2];
    f.vid = vid;
    for (int i = 0; i < 3; i++) begin
      f.tan[i] = 16'(d < 0 ? -tn[i] : tn[i]);
      f.bin[i] = 16'(d < 0 ? -bn[i] : bn[i]);
    end
    f.degen = z;
    f.last = last;
    return f;
  endfunction

  // Update the store or queue the three corner frames of a transfer
  task automatic predict_transfer();
    int idx [3];
    logic [9:0] fld [3];
    if (cmd_i == CMD_LOAD) begin
      pos_mem[vertex_slot_i][0] = longint'(pos_x_i);
      pos_mem[vertex_slot_i][1] = longint'(pos_y_i);
      pos_mem[vertex_slot_i][2] = longint'(pos_z_i);
      tex_mem[vertex_slot_i][0] = longint'(tex_u_i);
      tex_mem[vertex_slot_i][1] = longint'(tex_v_i);
    end else begin
      fld[0] = corner_a_i;
      fld[1] = corner_b_i;
      fld[2] = corner_c_i;
      for (int k = 0; k < 3; k++) idx[k] = int'(fld[k]) % VERTEX_DEPTH;
      for (int k = 0; k < 3; k++)
        expected_frames.push_back(corner_frame(idx[k], idx[(k + 1) % 3], idx[(k + 2) % 3],
                                               fld[k], k == 2));
    end
  endtask

  // Driver: bursts of back-to-back commands separated by random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i) begin
    cmd_item_t it;
    if (rst_ni) begin
      if (start && !busy) predict_transfer();
      if (start && busy) begin
        // hold the current command
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_cmds.size() == 0) begin
        start <= 1'b0;
      end else begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 8);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
        end
        if (gap_left > 0) begin
          start <= 1'b0;
        end else begin
          burst_left--;
          it = pending_cmds.pop_front();
          start <= 1'b1;
          cmd_i <= it.cmd;
          vertex_slot_i <= it.slot;
          pos_x_i <= it.px;
          pos_y_i <= it.py;
          pos_z_i <= it.pz;
          tex_u_i <= it.u;
          tex_v_i <= it.v;
          corner_a_i <= it.ca;
          corner_b_i <= it.cb;
          corner_c_i <= it.cc;
        end
      end
    end
  end

  // Monitor: every strobe is checked against the oldest expected frame
  always @(posedge clk_i) begin
    frame_t w;
    if (rst_ni && result_valid_o) begin
      if (expected_frames.size() == 0) begin
        report_mismatch("unexpected result, vertex_id", vertex_id_o, -1);
      end else begin
        w = expected_frames.pop_front();
        if (vertex_id_o !== w.vid) report_mismatch("vertex_id", vertex_id_o, w.vid);
        if (tangent_x_o !== w.tan[0])
          report_mismatch("tangent_x", tangent_x_o, $signed(w.tan[0]));
        if (tangent_y_o !== w.tan[1])
          report_mismatch("tangent_y", tangent_y_o, $signed(w.tan[1]));
        if (tangent_z_o !== w.tan[2])
          report_mismatch("tangent_z", tangent_z_o, $signed(w.tan[2]));
        if (binormal_x_o !== w.bin[0])
          report_mismatch("binormal_x", binormal_x_o, $signed(w.bin[0]));
        if (binormal_y_o !== w.bin[1])
          report_mismatch("binormal_y", binormal_y_o, $signed(w.bin[1]));
        if (binormal_z_o !== w.bin[2])
          report_mismatch("binormal_z", binormal_z_o, $signed(w.bin[2]));
        if (degenerate_o !== w.degen) report_mismatch("degenerate", degenerate_o, w.degen);
        if (last_corner_o !== w.last) report_mismatch("last_corner", last_corner_o, w.last);
      end
    end
  end

  // Stimulus helpers
  int written_slots [$];
  bit written [VERTEX_DEPTH];

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom);
      1:       return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default: return 16'($signed($urandom_range(0, 2047)) - 1024);
    endcase
  endfunction

  task automatic add_load(input int slot, input logic [15:0] px, py, pz, u, v);
    cmd_item_t it;
    it.cmd = CMD_LOAD;
    it.slot = 10'(slot);
    it.px = px; it.py = py; it.pz = pz; it.u = u; it.v = v;
    it.ca = 10'($urandom); it.cb = 10'($urandom); it.cc = 10'($urandom);
    pending_cmds.push_back(it);
    if (!written[slot]) written_slots.push_back(slot);
    written[slot] = 1'b1;
  endtask

  task automatic add_tri(input int a, input int b, input int c);
    cmd_item_t it;
    it.cmd = CMD_TRI;
    it.ca = 10'(a); it.cb = 10'(b); it.cc = 10'(c);
    it.slot = 10'($urandom);
    it.px = 16'($urandom); it.py = 16'($urandom); it.pz = 16'($urandom);
    it.u = 16'($urandom); it.v = 16'($urandom);
    pending_cmds.push_back(it);
  endtask

  function automatic int pick_slot();
    return written_slots[$urandom_range(0, written_slots.size() - 1)];
  endfunction

  initial begin
    int n_items;
    int n_verts;
    int base [$];
    int s;
    for (int i = 0; i < VERTEX_DEPTH; i++) written[i] = 1'b0;

    // directed: extremes, regular triangle, degenerate shapes
    add_load(0, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    add_load(1023, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    add_load(1, 16'h7fff, 16'h8000, 16'h0000, 16'h8000, 16'h7fff);
    add_tri(0, 1023, 1);
    add_load(2, 16'h0100, 16'h0000, 16'h0000, 16'h1000, 16'h0000);
    add_load(3, 16'h0000, 16'h0100, 16'h0000, 16'h0000, 16'h1000);
    add_load(4, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    add_tri(4, 2, 3);
    add_tri(4, 3, 2);   // mirrored winding flips the frame
    add_tri(2, 2, 2);   // all corners the same: zero edges
    add_tri(2, 2, 3);   // repeated corner
    add_load(5, 16'h0200, 16'h0000, 16'h0000, 16'h1000, 16'h1000);
    add_tri(4, 2, 5);   // collinear: zero normal
    add_load(6, 16'h0000, 16'h0100, 16'h0000, 16'h0000, 16'h0000);
    add_tri(4, 2, 6);   // equal texcoords on one edge pair
    add_load(7, 16'h1234, 16'hedcb, 16'h0042, 16'h0000, 16'h0000);
    add_tri(4, 7, 6);   // texcoords that give a zero binormal
    add_load(512, 16'h5555, 16'haaaa, 16'h3333, 16'hcccc, 16'h0f0f);
    add_tri(1023, 512, 0);
    add_tri(512, 0, 1023);

    // random: small meshes loaded then triangulated, with some noise
    n_items = pending_cmds.size();
    while (n_items < 330) begin
      n_verts = $urandom_range(3, 5);
      base.delete();
      for (int i = 0; i < n_verts; i++) begin
        s = $urandom_range(0, VERTEX_DEPTH - 1);
        add_load(s, rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord());
        base.push_back(s);
      end
      n_items += n_verts;
      for (int t = $urandom_range(1, 3); t > 0; t--) begin
        if ($urandom_range(0, 9) == 0)
          add_tri(pick_slot(), pick_slot(), pick_slot());
        else
          add_tri(base[$urandom_range(0, n_verts - 1)], base[$urandom_range(0, n_verts - 1)],
                  base[$urandom_range(0, n_verts - 1)]);
        n_items++;
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // drain: all commands taken, then all frames seen
    do @(posedge clk_i); while (pending_cmds.size() != 0 || start);
    do @(posedge clk_i); while (expected_frames.size() != 0);
    repeat (100) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
